// ----- sv/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned PHASE_TICKS_W     = 16;
  localparam int unsigned BIT_CNT_W         = 4;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned IN_TDATA_W        = 16;
  localparam int unsigned OUT_TDATA_W       = 16;

  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd4;
  localparam logic [BIT_CNT_W-1:0]     BITS_PER_BYTE     = 4'd8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    QTR_0 = 2'd0,
    QTR_1 = 2'd1,
    QTR_2 = 2'd2,
    QTR_3 = 2'd3
  } quarter_t;

endpackage

// ----- sv/i2c_master_byte_engine_unit.sv -----
// A result beat is registered in the output register when its tick is accepted.
// Throughput: one tick beat per cycle; the output register takes a new result whenever
//   it is empty or its beat is taken in the same cycle.
// Reset (rst_n low, synchronous): engine idle with both lines released, phase_ticks = 4,
//   received byte 0, acknowledge 1, output register empty.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Tick-driven open-drain I2C master: start, write byte, read byte and stop,
// four quarter phases per SCL bit, clock stretching in the high quarter.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // phase_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd_valid[0], opcode[2:1], tx_byte[10:3], nack_after_read[11], scl_in[12],
  // sda_in[13], zero[15:14]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_drive_low[0], sda_drive_low[1], ready_res[2], done_res[3], rx_byte[11:4],
  // ack_bit[12], zero[15:13]
  output logic [15:0] out_tdata
);

  localparam int unsigned PTW = i2cmbe_pkg::PHASE_TICKS_W;
  localparam int unsigned BW  = i2cmbe_pkg::BYTE_W;

  // input fields
  logic                  cmd_valid;
  i2cmbe_pkg::op_t       opcode;
  logic [BW-1:0]         tx_byte;
  logic                  nack_after_read;
  logic                  scl_in;
  logic                  sda_in;

  assign cmd_valid       = in_tdata[0];
  assign opcode          = i2cmbe_pkg::op_t'(in_tdata[2:1]);
  assign tx_byte         = in_tdata[10:3];
  assign nack_after_read = in_tdata[11];
  assign scl_in          = in_tdata[12];
  assign sda_in          = in_tdata[13];

  // engine state
  logic [PTW-1:0]                        phase_ticks_r;
  logic                                  busy_r,        busy_nxt;
  i2cmbe_pkg::op_t                       cur_op_r,      cur_op_nxt;
  i2cmbe_pkg::quarter_t                  quarter_r,     quarter_nxt;
  logic [PTW-1:0]                        tick_r,        tick_nxt;
  logic [i2cmbe_pkg::BIT_CNT_W-1:0]      bit_r,         bit_nxt;
  logic [BW-1:0]                         shift_r,       shift_nxt;
  logic                                  send_nack_r,   send_nack_nxt;
  logic [BW-1:0]                         rx_hold_r,     rx_hold_nxt;
  logic                                  ack_hold_r,    ack_hold_nxt;
  logic                                  idle_scl_r,    idle_scl_nxt;
  logic                                  idle_sda_r,    idle_sda_nxt;

  logic                                  out_valid_r;
  logic [i2cmbe_pkg::OUT_TDATA_W-1:0]    out_data_r,    out_data_nxt;

  logic           in_fire;
  logic [PTW-1:0] pt_eff;
  logic [PTW:0]   tick_inc;
  logic           quarter_end;
  logic           in_byte;
  logic           scl_low, sda_low, ready, done;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign pt_eff    = (phase_ticks_r == '0) ? PTW'(1) : phase_ticks_r;
  assign tick_inc  = {1'b0, tick_r} + (PTW+1)'(1);
  assign in_byte   = bit_r < i2cmbe_pkg::BITS_PER_BYTE;

  always_comb begin
    busy_nxt      = busy_r;
    cur_op_nxt    = cur_op_r;
    quarter_nxt   = quarter_r;
    tick_nxt      = tick_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    send_nack_nxt = send_nack_r;
    rx_hold_nxt   = rx_hold_r;
    ack_hold_nxt  = ack_hold_r;
    idle_scl_nxt  = idle_scl_r;
    idle_sda_nxt  = idle_sda_r;
    scl_low       = idle_scl_r;
    sda_low       = idle_sda_r;
    ready         = 1'b0;
    done          = 1'b0;
    quarter_end   = 1'b0;

    if (!busy_r) begin
      ready = 1'b1;
      if (cmd_valid) begin
        busy_nxt    = 1'b1;
        cur_op_nxt  = opcode;
        quarter_nxt = i2cmbe_pkg::QTR_0;
        tick_nxt    = '0;
        bit_nxt     = '0;
        if (opcode == i2cmbe_pkg::OP_WRITE) begin
          shift_nxt = tx_byte;
        end else if (opcode == i2cmbe_pkg::OP_READ) begin
          shift_nxt     = '0;
          send_nack_nxt = nack_after_read;
        end
      end
    end else begin
      unique case (cur_op_r)
        i2cmbe_pkg::OP_START: begin
          scl_low = (quarter_r == i2cmbe_pkg::QTR_0) ? idle_scl_r
                                                     : (quarter_r == i2cmbe_pkg::QTR_3);
          sda_low = quarter_r[1];
        end
        i2cmbe_pkg::OP_STOP: begin
          scl_low = (quarter_r == i2cmbe_pkg::QTR_0);
          sda_low = !quarter_r[1];
        end
        default: begin
          scl_low = (quarter_r == i2cmbe_pkg::QTR_0) || (quarter_r == i2cmbe_pkg::QTR_3);
          if (in_byte) begin
            sda_low = (cur_op_r == i2cmbe_pkg::OP_WRITE) && !shift_r[BW-1];
          end else begin
            sda_low = (cur_op_r == i2cmbe_pkg::OP_READ) && !send_nack_r;
          end
        end
      endcase

      // stretch: hold the count in the high quarter while SCL reads low
      if (quarter_r != i2cmbe_pkg::QTR_1 || scl_in) begin
        if (tick_inc >= {1'b0, pt_eff}) begin
          tick_nxt    = '0;
          quarter_end = 1'b1;
        end else begin
          tick_nxt = tick_inc[PTW-1:0];
        end
      end

      if (quarter_end) begin
        if (cur_op_r == i2cmbe_pkg::OP_WRITE || cur_op_r == i2cmbe_pkg::OP_READ) begin
          if (quarter_r == i2cmbe_pkg::QTR_2) begin
            if (in_byte) begin
              if (cur_op_r == i2cmbe_pkg::OP_READ) begin
                shift_nxt = {shift_r[BW-2:0], sda_in};
              end
            end else if (cur_op_r == i2cmbe_pkg::OP_WRITE) begin
              ack_hold_nxt = sda_in;
            end
          end
          if (quarter_r == i2cmbe_pkg::QTR_3) begin
            if (cur_op_r == i2cmbe_pkg::OP_WRITE && in_byte) begin
              shift_nxt = {shift_r[BW-2:0], 1'b0};
            end
            if (!in_byte) begin
              if (cur_op_r == i2cmbe_pkg::OP_READ) begin
                rx_hold_nxt = shift_r;
              end
              busy_nxt     = 1'b0;
              done         = 1'b1;
              idle_scl_nxt = 1'b1;
              idle_sda_nxt = 1'b0;
              bit_nxt      = '0;
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end
        end else if (quarter_r == i2cmbe_pkg::QTR_3) begin
          busy_nxt     = 1'b0;
          done         = 1'b1;
          idle_scl_nxt = (cur_op_r == i2cmbe_pkg::OP_START);
          idle_sda_nxt = (cur_op_r == i2cmbe_pkg::OP_START);
        end
        quarter_nxt = i2cmbe_pkg::quarter_t'(quarter_r + 2'd1);
      end
    end

    out_data_nxt = {3'b000, ack_hold_nxt, rx_hold_nxt, done, ready, sda_low, scl_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmbe_pkg::PHASE_TICKS_RESET;
      busy_r        <= 1'b0;
      cur_op_r      <= i2cmbe_pkg::OP_START;
      quarter_r     <= i2cmbe_pkg::QTR_0;
      tick_r        <= '0;
      bit_r         <= '0;
      shift_r       <= '0;
      send_nack_r   <= 1'b0;
      rx_hold_r     <= '0;
      ack_hold_r    <= 1'b1;
      idle_scl_r    <= 1'b0;
      idle_sda_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_ticks_r <= cfg_wdata;
      end
      if (in_fire) begin
        busy_r      <= busy_nxt;
        cur_op_r    <= cur_op_nxt;
        quarter_r   <= quarter_nxt;
        tick_r      <= tick_nxt;
        bit_r       <= bit_nxt;
        shift_r     <= shift_nxt;
        send_nack_r <= send_nack_nxt;
        rx_hold_r   <= rx_hold_nxt;
        ack_hold_r  <= ack_hold_nxt;
        idle_scl_r  <= idle_scl_nxt;
        idle_sda_r  <= idle_sda_nxt;
      end
      out_valid_r <= in_fire || (out_valid_r && !out_tready);
    end
  end

  // payload: load with each accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_done_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[2]))
    else $error("done and ready reported on the same tick");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (quarter_r == i2cmbe_pkg::QTR_0 && tick_r == '0))
    else $error("idle engine holds a phase or tick count");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= i2cmbe_pkg::BITS_PER_BYTE)
    else $error("bit counter past the acknowledge bit");

  a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy_r) && $past(rst_n)) |-> (out_tvalid && out_tdata[3]))
    else $error("command finished without a done beat");
`endif

endmodule

// ----- tb/tb_i2c_master_byte_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine_unit
// Drives line-sample tick beats into the I2C master byte engine. The command
// runs are well formed or noisy, with stretched SCL and random SDA. Each
// result beat is checked against a cycle-true engine model kept here. Both
// stream sides idle at random, and the receiver holds off once for a long
// stretch. Phase length settings run from zero to full scale.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine_unit;

  localparam int SDA_RAND    = 0;
  localparam int SDA_LOW     = 1;
  localparam int SDA_ONE     = 2;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 120;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic            sda;
    logic            scl;
    logic            nack;
    logic [7:0]      tx;
    i2cmbe_pkg::op_t opcode;
    logic            cmd_valid;
  } tick_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] rx;
    logic       done;
    logic       ready;
    logic       sda_low;
    logic       scl_low;
  } line_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  tick_t pending_ticks[$];
  line_t expected_lines[$];
  tick_t cur_tick = '0;
  int    items_pushed = 0;
  int    checked_cnt = 0;
  int    err_cnt = 0;
  int    gen_span = 4;
  bit    quiet = 1'b0;

  // engine model state
  logic [15:0]          phase_ticks;
  i2cmbe_pkg::quarter_t qtr;
  logic                 engine_busy;
  i2cmbe_pkg::op_t      cur_op;
  logic [15:0]          tick_cnt;
  logic [3:0]           bit_cnt;
  logic [7:0]           shifter;
  logic                 nack_pending;
  logic [7:0]           rx_hold;
  logic                 ack_hold;
  logic                 idle_scl;
  logic                 idle_sda;

  i2c_master_byte_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic line_t step_engine(input tick_t t);
    line_t       r;
    logic [15:0] span;
    logic        q_end;
    span = (phase_ticks == '0) ? 16'd1 : phase_ticks;
    r = '0;
    if (!engine_busy) begin
      r.ready   = 1'b1;
      r.scl_low = idle_scl;
      r.sda_low = idle_sda;
      if (t.cmd_valid) begin
        engine_busy = 1'b1;
        cur_op      = t.opcode;
        qtr         = i2cmbe_pkg::QTR_0;
        tick_cnt    = '0;
        bit_cnt     = '0;
        if (t.opcode == i2cmbe_pkg::OP_WRITE) begin
          shifter = t.tx;
        end else if (t.opcode == i2cmbe_pkg::OP_READ) begin
          shifter      = '0;
          nack_pending = t.nack;
        end
      end
    end else begin
      case (cur_op)
        i2cmbe_pkg::OP_START: begin
          r.scl_low = (qtr == i2cmbe_pkg::QTR_0) ? idle_scl : (qtr == i2cmbe_pkg::QTR_3);
          r.sda_low = (qtr == i2cmbe_pkg::QTR_2) || (qtr == i2cmbe_pkg::QTR_3);
        end
        i2cmbe_pkg::OP_STOP: begin
          r.scl_low = (qtr == i2cmbe_pkg::QTR_0);
          r.sda_low = (qtr == i2cmbe_pkg::QTR_0) || (qtr == i2cmbe_pkg::QTR_1);
        end
        default: begin
          r.scl_low = (qtr == i2cmbe_pkg::QTR_0) || (qtr == i2cmbe_pkg::QTR_3);
          if (bit_cnt < i2cmbe_pkg::BITS_PER_BYTE) begin
            r.sda_low = (cur_op == i2cmbe_pkg::OP_WRITE) && !shifter[7];
          end else begin
            r.sda_low = (cur_op == i2cmbe_pkg::OP_READ) && !nack_pending;
          end
        end
      endcase

      // hold the count while SCL is stretched in the high quarter
      q_end = 1'b0;
      if (qtr != i2cmbe_pkg::QTR_1 || t.scl) begin
        if (int'(tick_cnt) + 1 >= int'(span)) begin
          tick_cnt = '0;
          q_end    = 1'b1;
        end else begin
          tick_cnt = tick_cnt + 16'd1;
        end
      end

      if (q_end) begin
        if (cur_op == i2cmbe_pkg::OP_WRITE || cur_op == i2cmbe_pkg::OP_READ) begin
          if (qtr == i2cmbe_pkg::QTR_2) begin
            if (bit_cnt < i2cmbe_pkg::BITS_PER_BYTE) begin
              if (cur_op == i2cmbe_pkg::OP_READ) shifter = {shifter[6:0], t.sda};
            end else if (cur_op == i2cmbe_pkg::OP_WRITE) begin
              ack_hold = t.sda;
            end
          end
          if (qtr == i2cmbe_pkg::QTR_3) begin
            if (cur_op == i2cmbe_pkg::OP_WRITE && bit_cnt < i2cmbe_pkg::BITS_PER_BYTE) begin
              shifter = {shifter[6:0], 1'b0};
            end
            if (bit_cnt >= i2cmbe_pkg::BITS_PER_BYTE) begin
              if (cur_op == i2cmbe_pkg::OP_READ) rx_hold = shifter;
              engine_busy = 1'b0;
              r.done      = 1'b1;
              idle_scl    = 1'b1;
              idle_sda    = 1'b0;
              bit_cnt     = '0;
            end else begin
              bit_cnt = bit_cnt + 4'd1;
            end
          end
        end else if (qtr == i2cmbe_pkg::QTR_3) begin
          engine_busy = 1'b0;
          r.done      = 1'b1;
          idle_scl    = (cur_op == i2cmbe_pkg::OP_START);
          idle_sda    = (cur_op == i2cmbe_pkg::OP_START);
        end
        qtr = i2cmbe_pkg::quarter_t'(qtr + 2'd1);
      end
    end
    r.rx  = rx_hold;
    r.ack = ack_hold;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (err_cnt < MAX_PRINTS) begin
      $display("mismatch at beat %0d: %s got %0h expected %0h", checked_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.cmd_valid = 1'($urandom);
    t.opcode    = i2cmbe_pkg::op_t'($urandom_range(0, 3));
    t.tx        = 8'($urandom);
    t.nack      = 1'($urandom);
    t.scl       = 1'($urandom);
    t.sda       = 1'($urandom);
    return t;
  endfunction

  function automatic tick_t busy_tick(input int sda_mode);
    tick_t t;
    t = rand_tick();
    t.cmd_valid = ($urandom_range(0, 7) == 0);
    if (sda_mode == SDA_LOW) t.sda = 1'b0;
    else if (sda_mode == SDA_ONE) t.sda = 1'b1;
    return t;
  endfunction

  task automatic push_tick(input tick_t t);
    pending_ticks.push_back(t);
    items_pushed++;
  endtask

  task automatic idle_ticks(input int n);
    tick_t t;
    repeat (n) begin
      t = rand_tick();
      t.cmd_valid = 1'b0;
      push_tick(t);
    end
  endtask

  task automatic run_cmd(input i2cmbe_pkg::op_t op, input logic [7:0] tx, input logic nack,
                         input int sda_mode, input int stretch_pct);
    tick_t t;
    int    nq;
    int    q;
    int    k;
    t = rand_tick();
    t.cmd_valid = 1'b1;
    t.opcode    = op;
    t.tx        = tx;
    t.nack      = nack;
    push_tick(t);
    nq = (op == i2cmbe_pkg::OP_START || op == i2cmbe_pkg::OP_STOP) ? 4 : 36;
    for (q = 0; q < nq; q++) begin
      for (k = 0; k < gen_span; k++) begin
        if (q % 4 == 1 && $urandom_range(0, 99) < stretch_pct) begin
          repeat ($urandom_range(1, 6)) begin
            t = busy_tick(sda_mode);
            t.scl = 1'b0;
            push_tick(t);
          end
        end
        t = busy_tick(sda_mode);
        if (q % 4 == 1) t.scl = 1'b1;
        push_tick(t);
      end
    end
  endtask

  task automatic random_txn();
    logic [7:0] addr;
    int         nbytes;
    int         i;
    if ($urandom_range(0, 4) == 0) begin
      run_cmd(i2cmbe_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
              SDA_RAND, 20);
    end else begin
      addr   = 8'($urandom);
      nbytes = $urandom_range(0, 3);
      run_cmd(i2cmbe_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RAND, 20);
      run_cmd(i2cmbe_pkg::OP_WRITE, addr, 1'($urandom),
              ($urandom_range(0, 3) == 0) ? SDA_RAND : SDA_LOW, 20);
      for (i = 0; i < nbytes; i++) begin
        if (addr[0]) begin
          run_cmd(i2cmbe_pkg::OP_READ, 8'($urandom), (i == nbytes - 1), SDA_RAND, 15);
        end else begin
          run_cmd(i2cmbe_pkg::OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 15);
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        run_cmd(i2cmbe_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 20);
      end
    end
    if ($urandom_range(0, 1) == 0) idle_ticks($urandom_range(1, 4));
  endtask

  task automatic random_phase(input int budget);
    int first;
    first = items_pushed;
    while (items_pushed - first < budget) random_txn();
  endtask

  task automatic set_phase_ticks(input logic [15:0] v);
    while (checked_cnt != items_pushed) @(posedge clk);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    phase_ticks  = v;
    gen_span     = (v == '0) ? 1 : int'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : drive
    logic v;
    int   gap_cnt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_cnt = 0;
    end else begin
      v = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_lines.push_back(step_engine(cur_tick));
        v = 1'b0;
      end
      if (!v) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          gap_cnt = $urandom_range(0, 14);
        end else if (pending_ticks.size() != 0) begin
          cur_tick = pending_ticks.pop_front();
          v = 1'b1;
        end
      end
      in_tvalid <= v;
      in_tdata  <= {2'b00, cur_tick};
    end
  end

  always @(posedge clk) begin : sink
    int  hold_cnt;
    bit  long_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      // long hold-off while the sender keeps offering beats
      if (!long_done && checked_cnt >= 600) begin
        hold_cnt  = LONG_HOLD;
        long_done = 1'b1;
      end else if (hold_cnt == 0 && !quiet && $urandom_range(0, 19) == 0) begin
        hold_cnt = $urandom_range(1, 15);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    line_t got;
    line_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[12:0];
      if (expected_lines.size() == 0) begin
        flag_mismatch("unexpected beat", int'(got), 0);
      end else begin
        want = expected_lines.pop_front();
        if (got.scl_low !== want.scl_low) begin
          flag_mismatch("scl_drive_low", int'(got.scl_low), int'(want.scl_low));
        end
        if (got.sda_low !== want.sda_low) begin
          flag_mismatch("sda_drive_low", int'(got.sda_low), int'(want.sda_low));
        end
        if (got.ready !== want.ready) begin
          flag_mismatch("ready_res", int'(got.ready), int'(want.ready));
        end
        if (got.done !== want.done) begin
          flag_mismatch("done_res", int'(got.done), int'(want.done));
        end
        if (got.rx !== want.rx) begin
          flag_mismatch("rx_byte", int'(got.rx), int'(want.rx));
        end
        if (got.ack !== want.ack) begin
          flag_mismatch("ack_bit", int'(got.ack), int'(want.ack));
        end
      end
      checked_cnt++;
    end
  end

  always @(posedge clk) begin : watchdog
    int stuck;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STALL_LIMIT) begin
      $display("i2c_master_byte_engine_unit verification failed");
      $finish;
    end
  end

  initial begin
    phase_ticks  = i2cmbe_pkg::PHASE_TICKS_RESET;
    qtr          = i2cmbe_pkg::QTR_0;
    engine_busy  = 1'b0;
    cur_op       = i2cmbe_pkg::OP_START;
    tick_cnt     = '0;
    bit_cnt      = '0;
    shifter      = '0;
    nack_pending = 1'b0;
    rx_hold      = '0;
    ack_hold     = 1'b1;
    idle_scl     = 1'b0;
    idle_sda     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset phase length
    idle_ticks(2);
    run_cmd(i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 0);
    run_cmd(i2cmbe_pkg::OP_STOP, 8'hFF, 1'b1, SDA_RAND, 50);

    set_phase_ticks(16'd1);
    run_cmd(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND, 0);
    run_cmd(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b1, SDA_LOW, 0);
    run_cmd(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b0, SDA_ONE, 0);
    run_cmd(i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 0);
    run_cmd(i2cmbe_pkg::OP_START, 8'hA5, 1'b0, SDA_RAND, 0);
    run_cmd(i2cmbe_pkg::OP_READ, 8'h5A, 1'b1, SDA_ONE, 0);
    run_cmd(i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, SDA_LOW, 100);
    run_cmd(i2cmbe_pkg::OP_WRITE, 8'h81, 1'b0, SDA_RAND, 100);
    run_cmd(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND, 100);

    set_phase_ticks(16'd0);
    random_phase(100);
    set_phase_ticks(16'd1);
    random_phase(150);
    set_phase_ticks(16'd2);
    random_phase(150);
    set_phase_ticks(16'($urandom_range(3, 6)));
    random_phase(100);
    set_phase_ticks(16'd1);
    random_phase(100);

    // full-scale phase length: only the opening quarter of a start fits
    quiet = 1'b1;
    set_phase_ticks(16'hFFFF);
    gen_span = 10;
    run_cmd(i2cmbe_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RAND, 0);

    while (checked_cnt != items_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("i2c_master_byte_engine_unit verification clean");
    end else begin
      $display("i2c_master_byte_engine_unit verification failed");
    end
    $finish;
  end

endmodule
